>>> rtl/sos_pkg.sv
// Shared constants, codes and beat types for the sweep object segmenter.
package sos_pkg;

  localparam int LOOKBACK = 2;
  localparam logic [3:0] OBJECT_LIMIT = 4'd15;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH_DEG  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_CAP        = 2'd2;

  localparam logic [11:0] JUMP_THRESHOLD_RST = 12'd200;
  localparam logic [7:0]  MIN_WIDTH_RST      = 8'd5;
  localparam logic [3:0]  OBJ_CAP_RST        = 4'd8;

  localparam logic [9:0]  FULL_ANGLE     = 10'd180;
  localparam logic [18:0] DEG_TO_RAD_Q24 = 19'd292818;
  localparam logic [14:0] WIDTH_SAT      = 15'h7FFF;

  localparam logic [1:0] KIND_OBJECT   = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_ABORTED  = 2'd2;

  localparam logic [7:0] CMD_SPACE = 8'h20;
  localparam logic [7:0] CMD_X     = 8'h78;
  localparam logic [7:0] CMD_M     = 8'h6D;

  typedef struct packed {
    logic        first_sample;
    logic        final_sample;
    logic        command_ready;
    logic [7:0]  command_byte;
    logic [7:0]  angle;
    logic [11:0] ir_raw;
    logic [12:0] sonar_dist;
  } sos_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  object_id;
    logic [7:0]  start_angle;
    logic [7:0]  end_angle;
    logic [7:0]  center_angle;
    logic [12:0] distance;
    logic [14:0] linear_width;
    logic [3:0]  kept_total;
    logic        last_of_run;
  } sos_out_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic mul1;
    logic mul2;
    logic load_obj;
    logic load_stat;
  } sos_cmd_t;

  typedef struct packed {
    logic upd_obj;
    logic upd_stat;
    logic stat_held;
    logic slot_free;
  } sos_status_t;

endpackage

>>> rtl/sweep_object_segmenter.sv
// Top level of the sweep object segmenter: controller plus datapath.
//
//  channel  | dir | handshake             | beat
//  ---------+-----+-----------------------+-------------------------
//  in       | in  | in_valid / in_stall   | sos_in_t sample
//  out      | out | out_valid / out_stall | sos_out_t result
//  cfg      | in  | cfg_we                | cfg_index, cfg_data
//
// One sample at a time. A sample with no result returns to idle after its update;
// a status result then waits for a free output slot; an object result first goes
// through the two-stage width multiply, and a status beat may follow the object beat.
// Output register lets the next sample enter while the last beat waits.
// Reset is synchronous; in_stall is high during reset.
module sweep_object_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sos_pkg::sos_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sos_pkg::sos_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [sos_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sos_pkg::*;

  sos_cmd_t    cmd;
  sos_status_t status;

  sos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sos_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/sos_datapath.sv
// Datapath: sweep state, edge detection, object close, width multiply, output register.
module sos_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sos_pkg::sos_in_t                  in_data,
  input  logic                              cfg_we,
  input  logic [sos_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  sos_pkg::sos_cmd_t                 cmd,
  output sos_pkg::sos_status_t              status,
  input  logic                              out_stall,
  output logic                              out_valid,
  output sos_pkg::sos_out_t                 out_data
);
  import sos_pkg::*;

  localparam logic [7:0] LB8  = 8'(LOOKBACK);
  localparam logic [9:0] LB10 = 10'(LOOKBACK);

  logic [11:0] jump_threshold;
  logic [7:0]  min_width_deg;
  logic [3:0]  obj_cap;

  sos_in_t     in_q;
  logic [11:0] ir_hist [LOOKBACK];
  logic        in_obj;
  logic        sweep_done;
  logic [7:0]  obj_start;
  logic [12:0] near_dist;
  logic [7:0]  near_angle;
  logic [3:0]  kept;

  logic [3:0]  res_id;
  logic [7:0]  res_start;
  logic [7:0]  res_end;
  logic [7:0]  res_center;
  logic [12:0] res_dist;
  logic [7:0]  res_w;
  logic [3:0]  res_count;
  logic [1:0]  stat_kind;
  logic        stat_held;
  logic [20:0] prod1;
  logic [39:0] prod2;

  logic [11:0] hist_eff   [LOOKBACK];
  logic [11:0] hist_shift [LOOKBACK];
  logic        first;
  logic        eff_done;
  logic        eff_in_obj;
  logic [3:0]  eff_kept;
  logic        abort_byte;
  logic        abort;
  logic        proc;
  logic [11:0] past;
  logic [11:0] ir;
  logic        rise;
  logic        fall;
  logic [3:0]  limit;
  logic        can_keep;
  logic        inside_mid;
  logic [7:0]  start_n;
  logic [12:0] near_d_n;
  logic [7:0]  near_a_n;
  logic        close_fall;
  logic        close_final;
  logic [9:0]  close_end;
  logic signed [9:0] w_s;
  logic        keep;
  logic [3:0]  kept_inc;
  logic [3:0]  kept_next;
  logic        has_stat;
  logic [40:0] width_sum;
  logic [16:0] width_q;
  logic [14:0] width_sat;

  assign first      = in_q.first_sample;
  assign ir         = in_q.ir_raw;
  assign eff_done   = first ? 1'b0 : sweep_done;
  assign eff_in_obj = first ? 1'b0 : in_obj;
  assign eff_kept   = first ? 4'd0 : kept;

  always_comb begin
    for (int i = 0; i < LOOKBACK; i++) begin
      hist_eff[i] = first ? ir : ir_hist[i];
    end
    hist_shift[0] = ir;
    for (int i = 1; i < LOOKBACK; i++) begin
      hist_shift[i] = hist_eff[i-1];
    end
  end

  always_comb begin
    abort_byte = in_q.command_byte inside {CMD_SPACE, CMD_X, CMD_M};
  end

  assign abort    = !eff_done && in_q.command_ready && abort_byte;
  assign proc     = !eff_done && !abort;
  assign past     = hist_eff[LOOKBACK-1];
  assign rise     = (ir > past) && ((ir - past) > jump_threshold);
  assign fall     = (past > ir) && ((past - ir) > jump_threshold);
  assign limit    = (obj_cap < OBJECT_LIMIT) ? obj_cap : OBJECT_LIMIT;
  assign can_keep = eff_kept < limit;

  always_comb begin
    inside_mid = eff_in_obj;
    start_n    = obj_start;
    near_d_n   = near_dist;
    near_a_n   = near_angle;
    close_fall = 1'b0;
    if (proc) begin
      if (!eff_in_obj) begin
        if (rise) begin
          inside_mid = 1'b1;
          near_d_n   = in_q.sonar_dist;
          near_a_n   = in_q.angle;
          start_n    = (in_q.angle >= LB8) ? in_q.angle - LB8 : 8'd0;
        end
      end else begin
        if (in_q.sonar_dist < near_dist) begin
          near_d_n = in_q.sonar_dist;
          near_a_n = in_q.angle;
        end
        if (fall) begin
          inside_mid = 1'b0;
          close_fall = can_keep;
        end
      end
    end
  end

  assign close_final = proc && in_q.final_sample && inside_mid && can_keep;
  assign close_end   = close_fall ? ({2'b00, in_q.angle} - LB10) : FULL_ANGLE;
  assign w_s         = $signed(close_end) - $signed({2'b00, start_n});
  assign keep        = (close_fall || close_final) && (w_s >= $signed({2'b00, min_width_deg}));
  assign kept_inc    = eff_kept + 4'(keep);
  assign kept_next   = proc ? kept_inc : eff_kept;
  assign has_stat    = abort || (proc && in_q.final_sample);

  assign width_sum = {1'b0, prod2} + (41'd1 << 23);
  assign width_q   = width_sum[40:24];
  assign width_sat = (width_q > 17'(WIDTH_SAT)) ? WIDTH_SAT : width_q[14:0];

  assign status.upd_obj   = keep;
  assign status.upd_stat  = has_stat;
  assign status.stat_held = stat_held;
  assign status.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= JUMP_THRESHOLD_RST;
      min_width_deg  <= MIN_WIDTH_RST;
      obj_cap        <= OBJ_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_JUMP_THRESHOLD: jump_threshold <= cfg_data;
        CFG_MIN_WIDTH_DEG:  min_width_deg  <= cfg_data[7:0];
        CFG_OBJ_CAP:        obj_cap        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOOKBACK; i++) begin
        ir_hist[i] <= 12'd0;
      end
      in_obj     <= 1'b0;
      sweep_done <= 1'b1;
      obj_start  <= 8'd0;
      near_dist  <= 13'd0;
      near_angle <= 8'd0;
      kept       <= 4'd0;
      stat_held  <= 1'b0;
    end else if (cmd.update) begin
      for (int i = 0; i < LOOKBACK; i++) begin
        ir_hist[i] <= proc ? hist_shift[i] : hist_eff[i];
      end
      in_obj     <= proc && !in_q.final_sample && inside_mid;
      sweep_done <= eff_done || has_stat;
      obj_start  <= start_n;
      near_dist  <= near_d_n;
      near_angle <= near_a_n;
      kept       <= kept_next;
      stat_held  <= has_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_data;
    end
    if (cmd.update) begin
      res_id     <= kept_inc;
      res_start  <= start_n;
      res_end    <= close_end[7:0];
      res_center <= near_a_n;
      res_dist   <= near_d_n;
      res_w      <= w_s[7:0];
      res_count  <= kept_next;
      stat_kind  <= abort ? KIND_ABORTED : KIND_FINISHED;
    end
    if (cmd.mul1) begin
      prod1 <= 21'(res_dist) * 21'(res_w);
    end
    if (cmd.mul2) begin
      prod2 <= {19'd0, prod1} * {21'd0, DEG_TO_RAD_Q24};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_obj || cmd.load_stat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_obj) begin
      out_data.kind         <= KIND_OBJECT;
      out_data.object_id    <= res_id;
      out_data.start_angle  <= res_start;
      out_data.end_angle    <= res_end;
      out_data.center_angle <= res_center;
      out_data.distance     <= res_dist;
      out_data.linear_width <= width_sat;
      out_data.kept_total   <= res_count;
      out_data.last_of_run  <= !stat_held;
    end else if (cmd.load_stat) begin
      out_data.kind         <= stat_kind;
      out_data.object_id    <= 4'd0;
      out_data.start_angle  <= 8'd0;
      out_data.end_angle    <= 8'd0;
      out_data.center_angle <= 8'd0;
      out_data.distance     <= 13'd0;
      out_data.linear_width <= 15'd0;
      out_data.kept_total   <= res_count;
      out_data.last_of_run  <= 1'b1;
    end
  end

  a_done_not_inside: assert property (@(posedge clk) disable iff (rst)
    !(in_obj && sweep_done))
    else $error("object open while sweep is done");

  a_obj_angles: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_OBJECT)
      |-> (out_data.end_angle >= out_data.start_angle))
    else $error("object beat with end angle before start angle");

  a_obj_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_OBJECT)
      |-> (out_data.object_id != 4'd0 && out_data.object_id == out_data.kept_total))
    else $error("object id does not match kept count");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_obj && cmd.load_stat))
    else $error("two result loads in one cycle");

endmodule

>>> rtl/sos_ctrl.sv
// Controller: sequences capture, state update, width multiply and result beats.
module sos_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sos_pkg::sos_status_t status,
  output sos_pkg::sos_cmd_t    cmd
);
  import sos_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_UPDATE    = 3'd1;
  localparam logic [2:0] S_MUL1      = 3'd2;
  localparam logic [2:0] S_MUL2      = 3'd3;
  localparam logic [2:0] S_EMIT_OBJ  = 3'd4;
  localparam logic [2:0] S_EMIT_STAT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (status.upd_obj) begin
          state_next = S_MUL1;
        end else if (status.upd_stat) begin
          state_next = S_EMIT_STAT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_EMIT_OBJ;
      end
      S_EMIT_OBJ: begin
        if (status.slot_free) begin
          cmd.load_obj = 1'b1;
          state_next   = status.stat_held ? S_EMIT_STAT : S_IDLE;
        end
      end
      S_EMIT_STAT: begin
        if (status.slot_free) begin
          cmd.load_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the sweep object segmenter: directed and random sweeps.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sos_pkg::*;

  class sweep_ledger;
    logic [11:0] jump_thr;
    logic [7:0]  min_width;
    logic [3:0]  max_obj;
    logic [11:0] ir_hist [LOOKBACK];
    bit          in_obj;
    bit          done;
    logic [7:0]  obj_start;
    logic [12:0] near_dist;
    logic [7:0]  near_angle;
    logic [3:0]  kept;
    sos_out_t    expected_reports [$];
    int          failures;

    function new();
      int i;
      jump_thr = JUMP_THRESHOLD_RST;
      min_width = MIN_WIDTH_RST;
      max_obj = OBJ_CAP_RST;
      for (i = 0; i < LOOKBACK; i++) ir_hist[i] = '0;
      in_obj = 1'b0;
      done = 1'b1;
      obj_start = '0;
      near_dist = '0;
      near_angle = '0;
      kept = '0;
      failures = 0;
    endfunction

    function void set_regs(logic [11:0] thr, logic [7:0] minw, logic [3:0] maxo);
      jump_thr = thr;
      min_width = minw;
      max_obj = maxo;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function logic [14:0] arc_len(logic [12:0] d, int w);
      longint unsigned p;
      p = 64'(d) * 64'(w) * 64'(DEG_TO_RAD_Q24);
      p = (p + 64'd8388608) >> 24;
      return (p > 64'(WIDTH_SAT)) ? WIDTH_SAT : 15'(p);
    endfunction

    function void push_status(logic [1:0] k);
      sos_out_t r;
      r = '0;
      r.kind = k;
      r.kept_total = kept;
      expected_reports.push_back(r);
    endfunction

    function void close_span(int end_ang);
      int w;
      sos_out_t r;
      w = end_ang - int'(obj_start);
      if (w < int'(min_width)) return;
      kept = kept + 4'd1;
      r = '0;
      r.kind = KIND_OBJECT;
      r.object_id = kept;
      r.start_angle = obj_start;
      r.end_angle = 8'(end_ang);
      r.center_angle = near_angle;
      r.distance = near_dist;
      r.linear_width = arc_len(near_dist, w);
      r.kept_total = kept;
      expected_reports.push_back(r);
    endfunction

    function void take_sample(sos_in_t s);
      int past;
      int lim;
      int prior_len;
      int i;
      prior_len = expected_reports.size();
      if (s.first_sample) begin
        done = 1'b0;
        in_obj = 1'b0;
        kept = '0;
        for (i = 0; i < LOOKBACK; i++) ir_hist[i] = s.ir_raw;
      end
      if (done) return;
      if (s.command_ready && (s.command_byte == CMD_SPACE || s.command_byte == CMD_X ||
                              s.command_byte == CMD_M)) begin
        done = 1'b1;
        in_obj = 1'b0;
        push_status(KIND_ABORTED);
      end else begin
        past = int'(ir_hist[LOOKBACK-1]);
        for (i = LOOKBACK - 1; i > 0; i--) ir_hist[i] = ir_hist[i-1];
        ir_hist[0] = s.ir_raw;
        lim = (int'(max_obj) < int'(OBJECT_LIMIT)) ? int'(max_obj) : int'(OBJECT_LIMIT);
        if (!in_obj) begin
          if (int'(s.ir_raw) - past > int'(jump_thr)) begin
            in_obj = 1'b1;
            near_dist = s.sonar_dist;
            near_angle = s.angle;
            obj_start = (int'(s.angle) >= LOOKBACK) ? 8'(int'(s.angle) - LOOKBACK) : 8'd0;
          end
        end else begin
          if (s.sonar_dist < near_dist) begin
            near_dist = s.sonar_dist;
            near_angle = s.angle;
          end
          if (past - int'(s.ir_raw) > int'(jump_thr)) begin
            in_obj = 1'b0;
            if (int'(kept) < lim) close_span(int'(s.angle) - LOOKBACK);
          end
        end
        if (s.final_sample) begin
          if (in_obj && int'(kept) < lim) close_span(int'(FULL_ANGLE));
          in_obj = 1'b0;
          done = 1'b1;
          push_status(KIND_FINISHED);
        end
      end
      if (expected_reports.size() > prior_len)
        expected_reports[expected_reports.size()-1].last_of_run = 1'b1;
    endfunction

    function string show(sos_out_t r);
      return $sformatf({"kind=%0d id=%0d start=%0d end=%0d center=%0d dist=%0d ",
                        "width=%0d count=%0d last=%0b"},
                       r.kind, r.object_id, r.start_angle, r.end_angle, r.center_angle,
                       r.distance, r.linear_width, r.kept_total, r.last_of_run);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void match_report(sos_out_t got);
      sos_out_t want;
      if (expected_reports.size() == 0) begin
        flag({"unexpected beat: ", show(got)});
        return;
      end
      want = expected_reports.pop_front();
      if (got.kind !== want.kind || got.object_id !== want.object_id ||
          got.start_angle !== want.start_angle || got.end_angle !== want.end_angle ||
          got.center_angle !== want.center_angle || got.distance !== want.distance ||
          got.linear_width !== want.linear_width || got.kept_total !== want.kept_total ||
          got.last_of_run !== want.last_of_run)
        flag({"mismatch: want ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  sos_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sos_out_t out_data;
  logic     cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sweep_ledger sb = new();
  bit idle_in;
  bit idle_out;
  int hold_request;

  sweep_object_segmenter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.take_sample(in_data);
      if (out_valid && !out_stall) sb.match_report(out_data);
    end
  end

  function automatic int draw_gap(bit enabled);
    return enabled ? int'($urandom_range(0, 16)) : 0;
  endfunction

  function automatic sos_in_t sample_of(bit fs, bit ls, bit cr, logic [7:0] cb,
                                        logic [7:0] ang, logic [11:0] ir, logic [12:0] pd);
    sos_in_t s;
    s.first_sample = fs;
    s.final_sample = ls;
    s.command_ready = cr;
    s.command_byte = cb;
    s.angle = ang;
    s.ir_raw = ir;
    s.sonar_dist = pd;
    return s;
  endfunction

  task automatic send_sample(sos_in_t s);
    int gap;
    gap = draw_gap(idle_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_setup(logic [11:0] thr, logic [7:0] minw, logic [3:0] maxo);
    cfg_we <= 1'b1;
    cfg_index <= CFG_JUMP_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= CFG_MIN_WIDTH_DEG;
    cfg_data <= CFG_DATA_W'(minw);
    @(posedge clk);
    cfg_index <= CFG_OBJ_CAP;
    cfg_data <= CFG_DATA_W'(maxo);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(thr, minw, maxo);
  endtask

  task automatic run_sweep(inout int sent);
    int stride;
    int ang;
    int lo;
    int hi;
    int lvl;
    int k;
    bit high_lvl;
    bit ended;
    bit broken;
    logic [63:0] rnd;
    sos_in_t s;
    stride = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 9)) : 2;
    ang = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 20)) : 0;
    lo = $urandom_range(0, 2000);
    hi = $urandom_range(lo, 4095);
    broken = ($urandom_range(0, 9) == 0);
    high_lvl = 1'b0;
    ended = 1'b0;
    k = 0;
    while (!ended) begin
      if ($urandom_range(0, 7) == 0) high_lvl = !high_lvl;
      lvl = (high_lvl ? hi : lo) + int'($urandom_range(0, 60)) - 30;
      if (lvl < 0) lvl = 0;
      if (lvl > 4095) lvl = 4095;
      s = '0;
      s.first_sample = (k == 0);
      s.angle = 8'(ang);
      s.ir_raw = 12'(lvl);
      s.sonar_dist = 13'($urandom_range(0, 8191));
      if ($urandom_range(0, 150) == 0) begin
        s.command_ready = 1'b1;
        case ($urandom_range(0, 2))
          0: s.command_byte = CMD_SPACE;
          1: s.command_byte = CMD_X;
          default: s.command_byte = CMD_M;
        endcase
        ended = 1'b1;
      end else if ($urandom_range(0, 20) == 0) begin
        s.command_ready = 1'b1;
        s.command_byte = 8'($urandom_range(0, 255));
      end else begin
        s.command_byte = 8'($urandom_range(0, 255));
      end
      if (ang >= int'(FULL_ANGLE)) begin
        s.angle = 8'(FULL_ANGLE);
        s.final_sample = 1'b1;
        ended = 1'b1;
      end
      if ($urandom_range(0, 40) == 0) begin
        rnd = {$urandom, $urandom};
        s = rnd[$bits(sos_in_t)-1:0];
        s.angle = 8'($urandom_range(0, 180));
      end
      if (broken && k > 3 && $urandom_range(0, 30) == 0) ended = 1'b1;
      send_sample(s);
      sent++;
      ang += stride;
      k++;
    end
    if ($urandom_range(0, 4) == 0)
      send_sample(sample_of(1'b0, 1'b0, 1'b0, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 180)), 12'($urandom_range(0, 4095)),
                            13'($urandom_range(0, 8191))));
    if ($urandom_range(0, 7) == 0) drain();
  endtask

  initial begin
    int gap;
    out_stall <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        gap = draw_gap(idle_out);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    int sent;
    logic [11:0] thr;
    logic [7:0]  minw;
    logic [3:0]  maxo;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hold_request = 0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(sample_of(0, 0, 0, 8'h00, 10, 4095, 100));
    send_sample(sample_of(1, 0, 0, 8'h00, 0, 0, 8191));
    send_sample(sample_of(0, 0, 0, 8'h00, 2, 100, 4000));
    send_sample(sample_of(0, 0, 0, 8'h00, 4, 4095, 8191));
    send_sample(sample_of(0, 0, 0, CMD_X, 6, 4095, 1));
    send_sample(sample_of(0, 0, 1, 8'h41, 8, 4000, 300));
    send_sample(sample_of(0, 0, 0, 8'h00, 10, 0, 0));
    send_sample(sample_of(0, 0, 0, 8'h00, 12, 0, 500));
    send_sample(sample_of(0, 0, 0, 8'h00, 14, 3000, 700));
    send_sample(sample_of(0, 1, 0, 8'h00, 180, 3000, 50));
    send_sample(sample_of(0, 0, 0, 8'h00, 20, 0, 0));
    send_sample(sample_of(1, 0, 1, CMD_X, 0, 0, 0));
    send_sample(sample_of(1, 0, 0, 8'h00, 1, 0, 10));
    send_sample(sample_of(0, 0, 0, 8'h00, 1, 4095, 20));
    send_sample(sample_of(0, 0, 0, 8'h00, 3, 0, 30));
    send_sample(sample_of(0, 0, 0, 8'h00, 5, 0, 40));
    send_sample(sample_of(0, 0, 0, 8'h00, 9, 4095, 50));
    send_sample(sample_of(0, 0, 0, 8'h00, 8, 4095, 60));
    send_sample(sample_of(0, 0, 0, 8'h00, 8, 0, 70));
    send_sample(sample_of(0, 0, 1, CMD_M, 20, 0, 0));
    send_sample(sample_of(1, 1, 1, CMD_SPACE, 0, 4095, 8191));
    send_sample(sample_of(1, 0, 0, 8'h00, 0, 0, 0));
    send_sample(sample_of(0, 1, 1, CMD_SPACE, 180, 0, 0));
    send_sample(sample_of(1, 1, 0, 8'h00, 180, 4095, 8191));
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin thr = 12'd200; minw = 8'd5; maxo = 4'd8; end
        1: begin thr = 12'd0; minw = 8'd0; maxo = 4'd0; end
        2: begin thr = 12'd4095; minw = 8'd180; maxo = 4'd15; end
        3: begin thr = 12'd0; minw = 8'd0; maxo = 4'd15; end
        4: begin thr = 12'd60; minw = 8'd2; maxo = 4'd1; end
        5: begin thr = 12'($urandom_range(0, 300)); minw = 8'd100; maxo = 4'd15; end
        default: begin
          thr = 12'($urandom_range(0, 1200));
          minw = 8'($urandom_range(0, 24));
          maxo = 4'($urandom_range(0, 15));
        end
      endcase
      write_setup(thr, minw, maxo);
      case (phase)
        0: begin idle_in = 1'b0; idle_out = 1'b0; end
        1: begin idle_in = 1'b1; idle_out = 1'b1; end
        3: begin idle_in = 1'b0; idle_out = 1'b1; hold_request = 400; end
        default: begin
          idle_in = 1'($urandom_range(0, 1));
          idle_out = 1'($urandom_range(0, 1));
        end
      endcase
      sent = 0;
      while (sent < 220) run_sweep(sent);
      drain();
    end

    if (sb.pending() != 0)
      sb.flag($sformatf("%0d expected beats never arrived", sb.pending()));
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sos_pkg.sv
rtl/sos_datapath.sv
rtl/sos_ctrl.sv
rtl/sweep_object_segmenter.sv
test/tb_top.sv
